/* rtl/core/esc_drive_mode_tracker_core_assert.svh */
// Assertion macros shared by the drive mode tracker checker.
// No dependencies; included by the checker file.
`ifndef ESC_DRIVE_MODE_TRACKER_CORE_ASSERT_SVH
`define ESC_DRIVE_MODE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ESC_DMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esc_dmt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ESC_DMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esc_dmt: next-cycle check failed");

// Next-cycle implication that also holds during reset.
`define ESC_DMT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("esc_dmt: reset check failed");

`endif

/* rtl/core/esc_dmt_pkg.sv */
// Package for the drive mode tracker: register indices, mode and output bit
// positions, port widths and the random hold time function. No dependencies.
package esc_dmt_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISARM_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_FWD_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_FWD_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_REV_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_REV_MAX = 3'd7;

    localparam int MF_DISARM    = 0;
    localparam int MF_ABRK_FWD  = 1;
    localparam int MF_ABRK_REV  = 2;
    localparam int MF_FWD_ARMS  = 3;

    localparam int OUT_FWD   = 0;
    localparam int OUT_REV   = 1;
    localparam int OUT_BRAKE = 2;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    typedef logic [15:0] t_hold;

    // Returns lo + (((hi - lo + 1) * rnd) >> 16), or lo when hi is below lo.
    function automatic t_hold pick_hold(input t_hold lo, input t_hold hi, input t_hold rnd);
        logic [16:0] span;
        logic [32:0] prod;
        begin
            span = {1'b0, hi} - {1'b0, lo} + 17'd1;
            prod = 33'(span) * 33'(rnd);
            if (hi < lo) begin
                pick_hold = lo;
            end else begin
                pick_hold = lo + prod[31:16];
            end
        end
    endfunction

endpackage

/* rtl/core/esc_drive_mode_tracker_core.sv */
// Drive mode tracker core: input register, one pass of update logic and a
// result register, plus the configuration registers. Uses esc_dmt_pkg.
//
// Channel  Direction  Handshake                  Payload
// s        in         i_s_tvalid / o_s_tready    tick, new_sample, throttle, random_word
// m        out        o_m_tvalid / i_m_tready    forward, reversing, braking
// cfg      in         i_cfg_valid / o_cfg_ready  register index, write data
//
// Each transaction is held in the input register and is then written to the
// result register, and one transaction can be taken every cycle while the
// output is not stalled. The brake hold multiplier sits in the update logic
// between the two registers. Reset clears the drive state and loads the
// default configuration. A stalled output holds its result and the input
// register, and stops input only when both are full.
module esc_drive_mode_tracker_core #(
    parameter int REVERSE_HOLD_MIN = 50,
    parameter int REVERSE_HOLD_MAX = 100
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // [7:0] throttle, [23:8] random_word
    input  logic [esc_dmt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [0] tick, [1] new_sample
    input  logic [esc_dmt_pkg::IN_USER_W-1:0]     i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [0] forward, [1] reversing, [2] braking, [7:3] zero
    output logic [esc_dmt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [esc_dmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);
    import esc_dmt_pkg::*;

    logic [6:0]  r_neutral_high;
    logic [6:0]  r_neutral_low;
    logic [3:0]  r_mode_flags;
    t_hold       r_disarm_ticks;
    t_hold       r_brake_fwd_min;
    t_hold       r_brake_fwd_max;
    t_hold       r_brake_rev_min;
    t_hold       r_brake_rev_max;

    logic        r_in_valid;
    logic        r_tick;
    logic        r_new_sample;
    logic signed [7:0] r_throttle;
    t_hold       r_random_word;

    logic        r_out_valid;
    logic [2:0]  r_out_flags;

    logic        r_use_low;
    t_hold       r_disarm_count;
    t_hold       r_brake_count;
    t_hold       r_reverse_count;
    logic        r_fwd, r_rev, r_brk, r_dis, r_abrk, r_arev, r_armed;

    logic        n_use_low;
    t_hold       n_disarm_count;
    t_hold       n_brake_count;
    t_hold       n_reverse_count;
    logic        n_fwd, n_rev, n_brk, n_dis, n_abrk, n_arev, n_armed;

    logic        advance;
    logic [7:0]  mag;
    logic [6:0]  thresh;
    t_hold       brake_hold;
    t_hold       reverse_hold;

    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {5'd0, r_out_flags};
    assign o_cfg_ready = 1'b1;

    assign mag    = r_throttle[7] ? 8'(-r_throttle) : 8'(r_throttle);
    assign thresh = r_use_low ? r_neutral_low : r_neutral_high;

    assign reverse_hold = pick_hold(16'(REVERSE_HOLD_MIN), 16'(REVERSE_HOLD_MAX),
                                    r_random_word);
    assign brake_hold   = r_fwd ? pick_hold(r_brake_fwd_min, r_brake_fwd_max, r_random_word)
                                : pick_hold(r_brake_rev_min, r_brake_rev_max, r_random_word);

    always_comb begin
        n_use_low       = r_use_low;
        n_disarm_count  = r_disarm_count;
        n_brake_count   = r_brake_count;
        n_reverse_count = r_reverse_count;
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_brk   = r_brk;
        n_dis   = r_dis;
        n_abrk  = r_abrk;
        n_arev  = r_arev;
        n_armed = r_armed;

        if (r_tick) begin
            if (r_dis) begin
                n_disarm_count = r_disarm_count - 16'd1;
                if (n_disarm_count == 16'd0) begin
                    n_dis   = 1'b0;
                    n_armed = 1'b0;
                end
            end
            if (r_abrk) begin
                n_brake_count = r_brake_count - 16'd1;
                if (n_brake_count == 16'd0) begin
                    n_abrk = 1'b0;
                    n_brk  = 1'b0;
                end
            end
            if (r_arev) begin
                n_reverse_count = r_reverse_count - 16'd1;
                if (n_reverse_count == 16'd0) begin
                    n_arev = 1'b0;
                    n_rev  = 1'b0;
                end
            end
        end

        if (r_new_sample) begin
            if (mag < {1'b0, thresh}) begin
                n_use_low = 1'b0;
                if (n_fwd) begin
                    n_fwd = 1'b0;
                    if (r_mode_flags[MF_DISARM]) begin
                        n_dis          = 1'b1;
                        n_disarm_count = r_disarm_ticks;
                    end
                    if (r_mode_flags[MF_ABRK_FWD]) begin
                        n_brk         = 1'b1;
                        n_abrk        = 1'b1;
                        n_brake_count = brake_hold;
                    end
                end else if (n_rev) begin
                    if (!n_arev) begin
                        n_arev          = 1'b1;
                        n_reverse_count = reverse_hold;
                        if (r_mode_flags[MF_ABRK_REV]) begin
                            n_brk         = 1'b1;
                            n_abrk        = 1'b1;
                            n_brake_count = brake_hold;
                        end
                    end
                end else if (n_brk) begin
                    if (!n_abrk) begin
                        n_armed = 1'b0;
                        n_brk   = 1'b0;
                    end
                end
            end else begin
                n_use_low = 1'b1;
                n_abrk    = 1'b0;
                n_dis     = 1'b0;
                if (r_throttle[7]) begin
                    if (!n_armed) begin
                        n_rev  = 1'b1;
                        n_brk  = 1'b0;
                        n_fwd  = 1'b0;
                        n_arev = 1'b0;
                    end else begin
                        n_brk = 1'b1;
                        n_fwd = 1'b0;
                        n_rev = 1'b0;
                    end
                end else begin
                    n_fwd = 1'b1;
                    n_rev = 1'b0;
                    n_brk = 1'b0;
                    if (r_mode_flags[MF_FWD_ARMS]) begin
                        n_armed = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral_high  <= 7'd12;
            r_neutral_low   <= 7'd8;
            r_mode_flags    <= 4'd9;
            r_disarm_ticks  <= 16'd100;
            r_brake_fwd_min <= 16'd50;
            r_brake_fwd_max <= 16'd100;
            r_brake_rev_min <= 16'd50;
            r_brake_rev_max <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NEUTRAL_HIGH:  r_neutral_high  <= i_cfg_data[6:0];
                REG_NEUTRAL_LOW:   r_neutral_low   <= i_cfg_data[6:0];
                REG_MODE_FLAGS:    r_mode_flags    <= i_cfg_data[3:0];
                REG_DISARM_TICKS:  r_disarm_ticks  <= i_cfg_data;
                REG_BRAKE_FWD_MIN: r_brake_fwd_min <= i_cfg_data;
                REG_BRAKE_FWD_MAX: r_brake_fwd_max <= i_cfg_data;
                REG_BRAKE_REV_MIN: r_brake_rev_min <= i_cfg_data;
                REG_BRAKE_REV_MAX: r_brake_rev_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_tick        <= i_s_tuser[0];
            r_new_sample  <= i_s_tuser[1];
            r_throttle    <= i_s_tdata[7:0];
            r_random_word <= i_s_tdata[23:8];
        end
        if (advance) begin
            r_out_flags[OUT_FWD]   <= n_fwd;
            r_out_flags[OUT_REV]   <= n_rev;
            r_out_flags[OUT_BRAKE] <= n_brk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_low       <= 1'b0;
            r_disarm_count  <= 16'd0;
            r_brake_count   <= 16'd0;
            r_reverse_count <= 16'd0;
            r_fwd   <= 1'b0;
            r_rev   <= 1'b0;
            r_brk   <= 1'b0;
            r_dis   <= 1'b0;
            r_abrk  <= 1'b0;
            r_arev  <= 1'b0;
            r_armed <= 1'b0;
        end else if (advance) begin
            r_use_low       <= n_use_low;
            r_disarm_count  <= n_disarm_count;
            r_brake_count   <= n_brake_count;
            r_reverse_count <= n_reverse_count;
            r_fwd   <= n_fwd;
            r_rev   <= n_rev;
            r_brk   <= n_brk;
            r_dis   <= n_dis;
            r_abrk  <= n_abrk;
            r_arev  <= n_arev;
            r_armed <= n_armed;
        end
    end

endmodule

/* rtl/core/esc_dmt_checker.sv */
// Port-level checker for the drive mode tracker core and its bind.
// Depends on esc_dmt_pkg and esc_drive_mode_tracker_core_assert.svh.
`include "esc_drive_mode_tracker_core_assert.svh"

module esc_dmt_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_s_tready,
    input logic                                  o_m_tvalid,
    input logic                                  i_m_tready,
    input logic [esc_dmt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic                                  o_cfg_ready
);
    import esc_dmt_pkg::*;

    logic fwd_and_rev;
    logic fwd_and_brake;
    logic stall;

    assign fwd_and_rev   = o_m_tdata[OUT_FWD] && o_m_tdata[OUT_REV];
    assign fwd_and_brake = o_m_tdata[OUT_FWD] && o_m_tdata[OUT_BRAKE];
    assign stall         = o_m_tvalid && !i_m_tready;

    `ESC_DMT_ASSERT_NOW(a_fwd_rev_excl, i_clk, i_rst_n, o_m_tvalid, !fwd_and_rev)
    `ESC_DMT_ASSERT_NOW(a_fwd_brake_excl, i_clk, i_rst_n, o_m_tvalid, !fwd_and_brake)
    `ESC_DMT_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_s_tready, stall)
    `ESC_DMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_m_tvalid && $stable(o_m_tdata))
    `ESC_DMT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid && o_cfg_ready)

endmodule

bind esc_drive_mode_tracker_core esc_dmt_checker u_esc_dmt_checker (.*);
